// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// Depends on clk_i and rst_ni being in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RSQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsq assertion failed");

// Check an implication on every rising clock edge outside reset.
`define RSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsq implication failed");

`endif

// ----- design/rsq_pkg.sv -----
// Package for the reciprocal square root pipeline: float constants, the
// unpacked intermediate type and the shared normalize/round function.
`timescale 1ns / 1ps
package rsq_pkg;

  localparam logic [31:0] RsqMagic = 32'h5f3759df;
  localparam logic [31:0] FpHalf   = 32'h3f000000;
  localparam logic [31:0] FpOneHalf = 32'h3fc00000;
  localparam logic [31:0] CanonNan = 32'h7fc00000;
  localparam logic [7:0]  ExpMax   = 8'hff;

  // Unrounded result: value = w / 2^47 * 2^(e - 127), w not yet normalized.
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               s;
    logic signed [10:0] e;
    logic [47:0]        w;
  } unp_t;

  function automatic logic [5:0] lzc48(input logic [47:0] w);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (w[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Normalize, denormalize where needed, round to nearest even, pack.
  function automatic logic [31:0] fp_pack(input unp_t u);
    logic [5:0]         lz;
    logic [47:0]        wn;
    logic signed [10:0] e;
    logic signed [10:0] ee;
    logic [6:0]         sh;
    logic [95:0]        x;
    logic [47:0]        w2;
    logic               st;
    logic               up;
    logic [24:0]        k25;
    logic [23:0]        kept;
    logic [7:0]         field;
    logic [31:0]        res;
    lz = lzc48(u.w);
    wn = u.w << lz;
    e  = u.e - $signed({5'b0, lz});
    if (e < 11'sd1) begin
      ee = 11'sd1;
      sh = ((11'sd1 - e) > 11'sd48) ? 7'd48 : 7'(11'sd1 - e);
    end else begin
      ee = e;
      sh = 7'd0;
    end
    x    = {wn, 48'b0} >> sh;
    w2   = x[95:48];
    st   = (|x[47:0]) | (|w2[22:0]);
    up   = w2[23] & (st | w2[24]);
    k25  = {1'b0, w2[47:24]} + {24'b0, up};
    if (k25[24]) begin
      kept = k25[24:1];
      ee   = ee + 11'sd1;
    end else begin
      kept = k25[23:0];
    end
    field = kept[23] ? ee[7:0] : 8'd0;
    if (u.nan) begin
      res = CanonNan;
    end else if (u.inf || (ee >= 11'sd255)) begin
      res = {u.s, ExpMax, 23'b0};
    end else if (u.w == 48'b0) begin
      res = {u.s, 31'b0};
    end else begin
      res = {u.s, field, kept[22:0]};
    end
    return res;
  endfunction

endpackage

// ----- design/rsq_in_if.sv -----
// Input channel interface: valid/ready handshake with the operand bits.
// Standalone; no package needed.
`timescale 1ns / 1ps
interface rsq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  modport source (output valid, output operand_bits, input ready);
  modport sink (input valid, input operand_bits, output ready);
endinterface

// ----- design/rsq_out_if.sv -----
// Output channel interface: valid/ready handshake with the result bits.
// Standalone; no package needed.
`timescale 1ns / 1ps
interface rsq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, output result_bits, input ready);
  modport sink (input valid, input result_bits, output ready);
endinterface

// ----- design/rsq_fmul.sv -----
// Two-stage single-precision multiplier: mantissa product, then round/pack.
// Uses rsq_pkg for fp_pack and constants.
`timescale 1ns / 1ps
module rsq_fmul
  import rsq_pkg::*;
#(
  parameter int SideW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [31:0]      res_o,
  output logic [SideW-1:0] side_o
);

  logic v1_q, v2_q, en1, en2;
  unp_t u_d, u_q;
  logic [SideW-1:0] side1_q, side2_q;
  logic [31:0] res_q;

  logic [7:0] ea, eb;
  logic na, nb, ia, ib, za, zb;

  assign en2 = !v2_q || ready_i;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    na = (ea == ExpMax) && (a_i[22:0] != 23'b0);
    nb = (eb == ExpMax) && (b_i[22:0] != 23'b0);
    ia = (ea == ExpMax) && (a_i[22:0] == 23'b0);
    ib = (eb == ExpMax) && (b_i[22:0] == 23'b0);
    za = (ea == 8'd0) && (a_i[22:0] == 23'b0);
    zb = (eb == 8'd0) && (b_i[22:0] == 23'b0);
    u_d.nan = na | nb | (ia & zb) | (ib & za);
    u_d.inf = ia | ib;
    u_d.s   = a_i[31] ^ b_i[31];
    u_d.e   = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea})
            + $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd126;
    u_d.w   = {24'b0, (ea != 8'd0), a_i[22:0]} * {24'b0, (eb != 8'd0), b_i[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      u_q     <= u_d;
      side1_q <= side_i;
    end
    if (en2 && v1_q) begin
      res_q   <= fp_pack(u_q);
      side2_q <= side1_q;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;
  assign side_o  = side2_q;

endmodule

// ----- design/rsq_fadd.sv -----
// Two-stage single-precision adder: align and add, then round/pack.
// Uses rsq_pkg for fp_pack and constants.
`timescale 1ns / 1ps
module rsq_fadd
  import rsq_pkg::*;
#(
  parameter int SideW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [31:0]      res_o,
  output logic [SideW-1:0] side_o
);

  logic v1_q, v2_q, en1, en2;
  unp_t u_d, u_q;
  logic [SideW-1:0] side1_q, side2_q;
  logic [31:0] res_q;

  logic [7:0]  ea, eb, el, es, d;
  logic [23:0] ma, mb, ml, ms;
  logic        sl, sss, big, sub, na, nb, ia, ib;
  logic [53:0] bx;
  logic [26:0] bs;
  logic [27:0] sum;

  assign en2 = !v2_q || ready_i;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    na  = (a_i[30:23] == ExpMax) && (a_i[22:0] != 23'b0);
    nb  = (b_i[30:23] == ExpMax) && (b_i[22:0] != 23'b0);
    ia  = (a_i[30:23] == ExpMax) && (a_i[22:0] == 23'b0);
    ib  = (b_i[30:23] == ExpMax) && (b_i[22:0] == 23'b0);
    ea  = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb  = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma  = {(a_i[30:23] != 8'd0), a_i[22:0]};
    mb  = {(b_i[30:23] != 8'd0), b_i[22:0]};
    big = (ea > eb) || ((ea == eb) && (ma >= mb));
    el  = big ? ea : eb;
    es  = big ? eb : ea;
    ml  = big ? ma : mb;
    ms  = big ? mb : ma;
    sl  = big ? a_i[31] : b_i[31];
    sss = big ? b_i[31] : a_i[31];
    sub = sl ^ sss;
    d   = ((el - es) > 8'd27) ? 8'd27 : (el - es);
    // Shift the smaller operand, folding lost bits into a sticky bit.
    bx  = {ms, 3'b0, 27'b0} >> d;
    bs  = {bx[53:28], bx[27] | (|bx[26:0])};
    sum = sub ? ({1'b0, ml, 3'b0} - {1'b0, bs}) : ({1'b0, ml, 3'b0} + {1'b0, bs});
    u_d.nan = na | nb | (ia & ib & (a_i[31] ^ b_i[31]));
    u_d.inf = ia | ib;
    if (ia) u_d.s = a_i[31];
    else if (ib) u_d.s = b_i[31];
    else if (sum == 28'b0) u_d.s = sub ? 1'b0 : sl;
    else u_d.s = sl;
    u_d.e = $signed({3'b0, el}) + 11'sd1;
    u_d.w = {sum, 20'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      u_q     <= u_d;
      side1_q <= side_i;
    end
    if (en2 && v1_q) begin
      res_q   <= fp_pack(u_q);
      side2_q <= side1_q;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;
  assign side_o  = side2_q;

endmodule

// ----- design/fast_inverse_square_root_top.sv -----
// Channel | dir | payload           | handshake
// in_i    | in  | operand_bits [32] | valid/ready, transaction on both high
// out_o   | out | result_bits  [32] | valid/ready, transaction on both high
//
// Five float units of two register stages each lie between in_i and out_o.
// One transaction per cycle is sustained while out_o stays ready; every stage has its own valid bit.
// A stall at out_o holds the output and fills bubbles upstream before in_i drops ready.
// Reset (rst_ni, asynchronous, active low) clears all valid bits.
// Depends on rsq_pkg, rsq_in_if, rsq_out_if, rsq_fmul, rsq_fadd, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fast_inverse_square_root_top
  import rsq_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  rsq_in_if.sink    in_i,
  rsq_out_if.source out_o
);

  logic [31:0] x, g0;
  logic        xnan;
  logic        v1, v2, v3, v4;
  logic        r1, r2, r3, r4;
  logic [31:0] half, hg, t, u, t_neg;
  logic [32:0] s1, s2, s3, s4;
  logic        nan_o;

  // Form the first guess from the raw bits: arithmetic shift, wrap subtract.
  assign x    = in_i.operand_bits;
  assign g0   = RsqMagic - {x[31], x[31:1]};
  assign xnan = (x[30:23] == ExpMax) && (x[22:0] != 23'b0);

  // half = x * 0.5; carry the guess and the NaN flag alongside.
  rsq_fmul #(.SideW(33)) u_mul_half (
    .clk_i, .rst_ni,
    .valid_i(in_i.valid), .ready_o(in_i.ready),
    .a_i(x), .b_i(FpHalf), .side_i({xnan, g0}),
    .valid_o(v1), .ready_i(r1), .res_o(half), .side_o(s1)
  );

  // hg = half * g
  rsq_fmul #(.SideW(33)) u_mul_hg (
    .clk_i, .rst_ni,
    .valid_i(v1), .ready_o(r1),
    .a_i(half), .b_i(s1[31:0]), .side_i(s1),
    .valid_o(v2), .ready_i(r2), .res_o(hg), .side_o(s2)
  );

  // t = hg * g
  rsq_fmul #(.SideW(33)) u_mul_t (
    .clk_i, .rst_ni,
    .valid_i(v2), .ready_o(r2),
    .a_i(hg), .b_i(s2[31:0]), .side_i(s2),
    .valid_o(v3), .ready_i(r3), .res_o(t), .side_o(s3)
  );

  // u = 1.5 - t, as 1.5 + (-t)
  assign t_neg = {~t[31], t[30:0]};
  rsq_fadd #(.SideW(33)) u_add_u (
    .clk_i, .rst_ni,
    .valid_i(v3), .ready_o(r3),
    .a_i(FpOneHalf), .b_i(t_neg), .side_i(s3),
    .valid_o(v4), .ready_i(r4), .res_o(u), .side_o(s4)
  );

  // result = g * u; the last stage register is the output register.
  rsq_fmul #(.SideW(1)) u_mul_res (
    .clk_i, .rst_ni,
    .valid_i(v4), .ready_o(r4),
    .a_i(s4[31:0]), .b_i(u), .side_i(s4[32]),
    .valid_o(out_o.valid), .ready_i(out_o.ready), .res_o(out_o.result_bits),
    .side_o(nan_o)
  );

  // A NaN operand always leaves as the canonical quiet NaN.
  `RSQ_ASSERT_IMP(a_nan_canon, out_o.valid && nan_o, out_o.result_bits == CanonNan)
  // With the output empty no stage can be stalled, so input must be ready.
  `RSQ_ASSERT_IMP(a_ready_when_empty, !out_o.valid, in_i.ready)

endmodule

// ----- tb/fast_inverse_square_root_top_test.sv -----
// Self-checking testbench for fast_inverse_square_root_top: random and directed
// operands, a bit-accurate single-precision predictor and an in-order check.
// Depends on rsq_pkg, rsq_in_if, rsq_out_if and the design top level.
`timescale 1ns / 1ps
module fast_inverse_square_root_top_test;
  import rsq_pkg::*;

  logic clk_i;
  logic rst_ni;

  rsq_in_if  in_if ();
  rsq_out_if out_if ();

  fast_inverse_square_root_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Operands waiting for the driver, results waiting for the output port.
  logic [31:0] pending_operands[$];
  logic [31:0] expected_results[$];
  int          error_count;

  // Idle percentages for sender and receiver; set per phase.
  int tx_idle_pct;
  int rx_idle_pct;
  logic rx_hold;
  logic hold_go;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Single-precision arithmetic, round to nearest even, subnormals kept.
  // ---------------------------------------------------------------------------
  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return f[30:0] == 31'h7f800000;
  endfunction

  function automatic logic is_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  // Split into an integer significand and a power of two: value = m * 2^e.
  function automatic void sp_split(input logic [31:0] f, output logic [23:0] m,
                                   output int e);
    if (f[30:23] == 8'd0) begin
      m = {1'b0, f[22:0]};
      e = -149;
    end else begin
      m = {1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
  endfunction

  // Round the exact nonzero value m * 2^e to a single-precision pattern.
  function automatic logic [31:0] sp_round(input logic s, input logic [127:0] m,
                                           input int e);
    int           p;
    int           ex;
    int           sh;
    logic [127:0] kept;
    logic [127:0] mask;
    logic         guard;
    logic         sticky;
    p = 0;
    for (int i = 0; i < 128; i++) begin
      if (m[i]) p = i;
    end
    ex = p + e;
    if (ex < -126) ex = -126;
    sh = (ex - 23) - e;
    if (sh <= 0) begin
      kept   = m << (-sh);
      guard  = 1'b0;
      sticky = 1'b0;
    end else if (sh >= 129) begin
      kept   = '0;
      guard  = 1'b0;
      sticky = 1'b1;
    end else begin
      kept   = m >> sh;
      guard  = m[sh-1];
      mask   = (128'd1 << (sh - 1)) - 128'd1;
      sticky = |(m & mask);
    end
    if (guard && (sticky || kept[0])) kept = kept + 128'd1;
    if (kept[24]) begin
      kept = kept >> 1;
      ex++;
    end
    if (ex > 127) return {s, 8'hff, 23'd0};
    if (!kept[23]) return {s, 8'h00, kept[22:0]};
    return {s, 8'(ex + 127), kept[22:0]};
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [23:0] ma;
    logic [23:0] mb;
    int          ea;
    int          eb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CanonNan;
    if (is_inf(a) || is_inf(b)) begin
      if (is_zero(a) || is_zero(b)) return CanonNan;
      return {s, 8'hff, 23'd0};
    end
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    sp_split(a, ma, ea);
    sp_split(b, mb, eb);
    return sp_round(s, 128'(ma) * 128'(mb), ea + eb);
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  tmp;
    logic [23:0]  ma;
    logic [23:0]  mb;
    int           ea;
    int           eb;
    int           d;
    logic [127:0] wa;
    logic [127:0] wb;
    logic [127:0] sum;
    logic         s;
    if (is_nan(a) || is_nan(b)) return CanonNan;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return CanonNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    sp_split(a, ma, ea);
    sp_split(b, mb, eb);
    if (eb > ea) begin
      tmp = a; a = b; b = tmp;
      sp_split(a, ma, ea);
      sp_split(b, mb, eb);
    end
    // A far smaller addend only matters as a sticky bit; shrink it to one.
    d = ea - eb;
    if (d > 60) begin
      mb = 24'd1;
      eb = ea - 60;
      d  = 60;
    end
    wa = 128'(ma) << d;
    wb = 128'(mb);
    if (a[31] == b[31]) begin
      sum = wa + wb;
      s   = a[31];
    end else if (wa >= wb) begin
      sum = wa - wb;
      s   = a[31];
    end else begin
      sum = wb - wa;
      s   = b[31];
    end
    if (sum == '0) return 32'd0;
    return sp_round(s, sum, eb);
  endfunction

  // Magic-constant guess followed by one Newton step in the fixed order.
  function automatic logic [31:0] rsqrt_expect(input logic [31:0] x);
    logic [31:0] guess;
    logic [31:0] half;
    logic [31:0] t;
    logic [31:0] u;
    logic [31:0] r;
    guess = RsqMagic - {x[31], x[31:1]};
    half  = sp_mul(x, FpHalf);
    t     = sp_mul(sp_mul(half, guess), guess);
    u     = sp_add(FpOneHalf, {~t[31], t[30:0]});
    r     = sp_mul(guess, u);
    return is_nan(r) ? CanonNan : r;
  endfunction

  // Operand mix: raw patterns, ordinary positives and the exponent extremes.
  function automatic logic [31:0] random_operand();
    int   pick;
    logic [7:0] ex;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 70) return {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
    if (pick < 85) begin
      ex = $urandom_range(1) ? 8'hff : 8'h00;
      return {1'($urandom), ex, 23'($urandom)};
    end
    case ($urandom_range(3))
      0: ex = 8'd1;
      1: ex = 8'd2;
      2: ex = 8'd253;
      default: ex = 8'd254;
    endcase
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next operand once the previous transaction is gone.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.operand_bits <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_operands.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_if.valid        <= 1'b1;
        in_if.operand_bits <= pending_operands.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls, or a long hold while the pipe backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long output hold, counted here so the sender keeps pushing meanwhile.
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transaction, check each output transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(rsqrt_expect(in_if.operand_bits));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_if.result_bits);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.result_bits !== want) begin
            $display("%0t: result_bits mismatch expected %h actual %h",
                     $time, want, out_if.result_bits);
            error_count++;
          end
        end
      end
    end
  end

  // Block until driver, pipeline and expectation store are all empty.
  task automatic drain();
    while (pending_operands.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_operands.push_back(random_operand());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corners, then three random phases with set idle rates.
  // ---------------------------------------------------------------------------
  initial begin
    error_count = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go     = 1'b0;
    rst_ni      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni = 1'b1;

    // Zeros, infinities, NaNs, subnormal and normal extremes, negatives.
    pending_operands = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                         32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
                         32'h007fffff, 32'h00800000, 32'h7f7fffff, 32'h3f800000,
                         32'h40800000, 32'hbf800000, 32'h80000001, 32'h807fffff,
                         32'h5f3759df, 32'h3e800000, 32'h00400000, 32'hff7fffff};
    drain();

    // Sender pauses above until all results are in; now back up the pipe.
    tx_idle_pct = 8;
    rx_idle_pct = 57;
    hold_go     = 1'b1;
    queue_random(620);
    drain();

    tx_idle_pct = 57;
    rx_idle_pct = 8;
    queue_random(620);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(640);
    drain();

    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
